### rtl/core/stup_pkg.sv
// shared types, constants and character helpers for the string to unsigned parser
// no dependencies; used by the front, queue, back and top level modules
package stup_pkg;

  // fixed field widths
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 16;
  localparam int BASE_W  = 6;
  localparam int DIGIT_W = 6;
  localparam int STAT_W  = 2;

  // queue between front and back
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // status codes
  localparam logic [STAT_W-1:0] ST_CONVERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_BASE  = 2'd2;

  // radix values
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  // digit code for a character that is no digit in any radix
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'h3f;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  // one classified character word
  typedef struct packed {
    logic               is_nul;
    logic               is_blank;
    logic               is_sign;
    logic               is_zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
  } entry_t;

  // queue fill status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  // parser phases, one-hot
  typedef enum logic [6:0] {
    PH_BLANK   = 7'b0000001,
    PH_START   = 7'b0000010,
    PH_ZERO    = 7'b0000100,
    PH_ZEROX   = 7'b0001000,
    PH_DIGITS  = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_INVALID = 7'b1000000
  } phase_t;

  // digit value of a character in radix up to 36
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    begin
      d = {CHAR_W{1'b1}};
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
        d = c - CH_UP_A + LETTER_OFS;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
        d = c - CH_LO_A + LETTER_OFS;
      end
      digit_of = (d == {CHAR_W{1'b1}}) ? DIGIT_NONE : d[DIGIT_W-1:0];
    end
  endfunction

endpackage

### rtl/core/stup_front.sv
// front part: accepts characters, classifies them and stamps their string position
// depends on stup_pkg
module stup_front import stup_pkg::*; #(
  parameter int MAX_STRING_LEN = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] char_in,
  input  queue_stat_t       q_stat,
  output logic              push,
  output entry_t            push_entry
);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_STRING_LEN);

  logic [POS_W-1:0] pos;

  // accept whenever the queue has room
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // classify the character
  always_comb begin
    push_entry.is_nul   = (char_in == CH_NUL);
    push_entry.is_blank = (char_in >= CH_TAB && char_in <= CH_CR) || (char_in == CH_SPACE);
    push_entry.is_sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);
    push_entry.is_zero  = (char_in == CH_ZERO);
    push_entry.is_x     = (char_in == CH_LO_X) || (char_in == CH_UP_X);
    push_entry.digit    = digit_of(char_in);
    push_entry.pos      = pos;
  end

  // position counter, saturating, restarts after the terminator
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      if (push_entry.is_nul) begin
        pos <= '0;
      end else if (pos < POS_LIMIT) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

endmodule

### rtl/core/stup_queue.sv
// short queue of classified character words between front and back
// depends on stup_pkg
module stup_queue import stup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      push_entry,
  input  logic        pop,
  output entry_t      head,
  output queue_stat_t q_stat
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign head         = slots[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

### rtl/core/stup_back.sv
// back part: parse state machine, digit multiply-add, radix register and result register
// depends on stup_pkg
module stup_back import stup_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [BASE_W-1:0]      cfg_write_data,
  input  entry_t                 head,
  input  queue_stat_t            q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] value,
  output logic [POS_W-1:0]       end_offset,
  output logic                   overflowed,
  output logic [STAT_W-1:0]      status
);

  localparam int MAC_W = VALUE_WIDTH + BASE_W;

  logic [BASE_W-1:0]      number_base;
  phase_t                 phase, phase_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   ovf, ovf_next;
  logic                   seen, seen_next;
  logic [BASE_W-1:0]      active_base, active_base_next;
  logic [POS_W-1:0]       stop_pos, stop_pos_next;
  logic [POS_W-1:0]       pending_pos, pending_pos_next;

  logic [BASE_W-1:0]      eff_base;
  logic [MAC_W-1:0]       mac;
  logic                   digit_ok;
  logic                   base_bad;
  logic                   take;
  logic                   emit;

  logic [VALUE_WIDTH-1:0] res_value;
  logic [POS_W-1:0]       res_end;
  logic                   res_ovf;
  logic [STAT_W-1:0]      res_status;

  // a terminator word waits until the result register is free
  assign pop  = !q_stat.empty && (!head.is_nul || !out_valid || !out_stall);
  assign emit = pop && head.is_nul;

  assign base_bad = (number_base == BASE_ONE) || (number_base > BASE_MAX);

  // radix applied to this character
  always_comb begin
    if (phase == PH_BLANK || phase == PH_START) begin
      if (number_base == BASE_AUTO) begin
        eff_base = head.is_zero ? BASE_OCT : BASE_DEC;
      end else begin
        eff_base = number_base;
      end
    end else if (phase == PH_ZEROX) begin
      eff_base = BASE_HEX;
    end else begin
      eff_base = active_base;
    end
  end

  assign digit_ok = (head.digit < eff_base);

  // one multiply-add per character
  assign mac = MAC_W'(acc) * MAC_W'(eff_base) + MAC_W'(head.digit);

  // next parse state
  always_comb begin
    phase_next       = phase;
    active_base_next = active_base;
    stop_pos_next    = stop_pos;
    pending_pos_next = pending_pos;
    take             = 1'b0;

    unique case (phase)
      PH_BLANK, PH_START: begin
        if (phase == PH_BLANK && head.is_blank) begin
          phase_next = PH_BLANK;
        end else if (phase == PH_BLANK && head.is_sign) begin
          phase_next = PH_START;
        end else if (head.is_zero &&
                     (number_base == BASE_HEX || number_base == BASE_AUTO)) begin
          active_base_next = eff_base;
          take             = 1'b1;
          phase_next       = PH_ZERO;
        end else if (base_bad) begin
          phase_next = PH_INVALID;
        end else begin
          active_base_next = eff_base;
          if (digit_ok) begin
            take       = 1'b1;
            phase_next = PH_DIGITS;
          end else begin
            stop_pos_next = head.pos;
            phase_next    = PH_DONE;
          end
        end
      end
      PH_ZERO: begin
        if (head.is_x) begin
          pending_pos_next = head.pos;
          phase_next       = PH_ZEROX;
        end else if (digit_ok) begin
          take       = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          stop_pos_next = head.pos;
          phase_next    = PH_DONE;
        end
      end
      PH_ZEROX: begin
        if (digit_ok) begin
          active_base_next = BASE_HEX;
          take             = 1'b1;
          phase_next       = PH_DIGITS;
        end else begin
          stop_pos_next = pending_pos;
          phase_next    = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit_ok) begin
          take = 1'b1;
        end else begin
          stop_pos_next = head.pos;
          phase_next    = PH_DONE;
        end
      end
      PH_DONE, PH_INVALID: begin
        phase_next = phase;
      end
      default: begin
        phase_next = PH_BLANK;
      end
    endcase

    acc_next  = take ? mac[VALUE_WIDTH-1:0] : acc;
    ovf_next  = ovf || (take && (mac[MAC_W-1:VALUE_WIDTH] != '0));
    seen_next = seen || take;
  end

  // result for a terminator word
  always_comb begin
    res_value  = '0;
    res_end    = '0;
    res_ovf    = 1'b0;
    res_status = ST_NO_DIGITS;
    if (phase == PH_BLANK || phase == PH_START) begin
      res_status = base_bad ? ST_BAD_BASE : ST_NO_DIGITS;
    end else if (phase == PH_INVALID) begin
      res_status = ST_BAD_BASE;
    end else if (seen) begin
      res_status = ST_CONVERTED;
      res_value  = ovf ? {VALUE_WIDTH{1'b1}} : acc;
      res_ovf    = ovf;
      if (phase == PH_ZERO || phase == PH_DIGITS) begin
        res_end = head.pos;
      end else if (phase == PH_ZEROX) begin
        res_end = pending_pos;
      end else begin
        res_end = stop_pos;
      end
    end
  end

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
    end else if (cfg_write_en) begin
      number_base <= cfg_write_data;
    end
  end

  // parse state, cleared after each string
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      phase       <= PH_BLANK;
      acc         <= '0;
      ovf         <= 1'b0;
      seen        <= 1'b0;
      active_base <= '0;
      stop_pos    <= '0;
      pending_pos <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      acc         <= acc_next;
      ovf         <= ovf_next;
      seen        <= seen_next;
      active_base <= active_base_next;
      stop_pos    <= stop_pos_next;
      pending_pos <= pending_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value      <= res_value;
      end_offset <= res_end;
      overflowed <= res_ovf;
      status     <= res_status;
    end
  end

endmodule

### rtl/core/string_to_unsigned_parser.sv
// top level of the streaming string to unsigned integer parser
// depends on stup_pkg, stup_front, stup_queue and stup_back
//
//   channel   handshake               payload
//   input     in_valid / in_stall     char_in[7:0]
//   output    out_valid / out_stall   value, end_offset[15:0], overflowed, status[1:0]
//   config    cfg_write_en            cfg_write_data[5:0] (radix)
//
// one character per cycle sustained while the queue is not full; a terminator is
// stored in the queue, and out_valid rises when the back part takes it from there
// into the result register
// a four-word queue sits between front and back, so input keeps flowing while a
// result waits in the output register
// rst is synchronous and clears the radix to auto, the queue and the parse state
module string_to_unsigned_parser import stup_pkg::*; #(
  parameter int VALUE_WIDTH    = 32,
  parameter int MAX_STRING_LEN = 65535
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [BASE_W-1:0]      cfg_write_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAR_W-1:0]      char_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] value,
  output logic [POS_W-1:0]       end_offset,
  output logic                   overflowed,
  output logic [STAT_W-1:0]      status
);

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      head;

  // accept and classify
  stup_front #(
    .MAX_STRING_LEN(MAX_STRING_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  stup_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // parse and emit
  stup_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .end_offset     (end_offset),
    .overflowed     (overflowed),
    .status         (status)
  );

endmodule
